[hdl/nwcc_pkg.sv]
// Shared types, codes and helpers for the NVRAM write-coalescing controller.
package nwcc_pkg;

   // Default depth of the write stack
   localparam int STACK_DEPTH_DEF = 8;
   // Depth of the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // Command codes on the request port
   localparam logic [2:0] CMD_WRITE = 3'd0;
   localparam logic [2:0] CMD_READ  = 3'd1;
   localparam logic [2:0] CMD_POLL  = 3'd2;
   localparam logic [2:0] CMD_DONE  = 3'd3;
   localparam logic [2:0] CMD_TICK  = 3'd4;

   // Classified operations handed to the back end
   typedef logic [2:0] op_type;
   localparam op_type OP_WRITE = 3'd0;
   localparam op_type OP_READ  = 3'd1;
   localparam op_type OP_POLL  = 3'd2;
   localparam op_type OP_DONE  = 3'd3;
   localparam op_type OP_TICK  = 3'd4;
   localparam op_type OP_NONE  = 3'd5;

   // Bus completion status codes
   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_NODEV = 2'd1;

   // Controller modes
   typedef logic [2:0] mode_type;
   localparam mode_type M_INIT   = 3'd0;
   localparam mode_type M_SETASE = 3'd1;
   localparam mode_type M_IDLE   = 3'd2;
   localparam mode_type M_BUSY   = 3'd3;
   localparam mode_type M_ERROR  = 3'd4;

   // Transfer kinds
   typedef logic [1:0] kind_type;
   localparam kind_type K_STATUS_RD = 2'd0;
   localparam kind_type K_CTRL_WR   = 2'd1;
   localparam kind_type K_DATA_WR   = 2'd2;
   localparam kind_type K_ADDR_RD   = 2'd3;

   // Configuration register indexes
   localparam logic REG_BYTE_ADDR_MODE = 1'b0;
   localparam logic REG_TIMEOUT        = 1'b1;

   // Device constants
   localparam logic [7:0]  DEV_SRAM      = 8'hA0;
   localparam logic [7:0]  DEV_CTRL      = 8'h30;
   localparam logic [7:0]  HI_BITS_MASK  = 8'h0E;
   localparam logic [7:0]  ASE_BIT       = 8'h02;
   localparam logic [15:0] TIMEOUT_RESET = 16'd500;
   localparam logic [15:0] ELAPSED_MAX   = 16'hFFFF;

   // One classified beat as it travels through the queue
   typedef struct packed {
      op_type      op;
      logic [15:0] addr;
      logic [7:0]  data;
      logic [15:0] len;
      logic        rdy;
      logic        acc;
      logic        st_ok;
      logic        st_nodev;
      logic [7:0]  sbyte;
   } item_type;

   typedef struct packed {
      logic        byte_addr_mode;
      logic [15:0] timeout_ticks;
   } cfg_type;

   typedef struct packed {
      logic        issue;
      kind_type    xfer_kind;
      logic [7:0]  dev_addr;
      logic [7:0]  tx_byte0;
      logic [7:0]  tx_byte1;
      logic [7:0]  tx_byte2;
      logic [1:0]  tx_count;
      logic [15:0] rx_count;
      logic        ready_res;
      logic        read_taken;
      logic        write_dropped;
      mode_type    ctrl_mode;
   } rsp_type;

   // Device address: in byte-address mode address bits 10..8 go into it
   function automatic logic [7:0] dev_for(input logic bam, input logic [15:0] a);
      logic [7:0] hi;
      hi = a[14:7] & HI_BITS_MASK;
      return bam ? (DEV_SRAM + hi) : DEV_SRAM;
   endfunction

endpackage

[hdl/nwcc_front.sv]
// Front end: accepts request beats, classifies them and tracks the busy flag.
module nwcc_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_cmd,
   input  logic [15:0]        req_addr,
   input  logic [7:0]         req_write_data,
   input  logic [15:0]        req_len,
   input  logic               req_bus_ready,
   input  logic               req_bus_accept,
   input  logic [1:0]         req_bus_status,
   input  logic [7:0]         req_status_byte,
   input  logic               done,
   output logic               push,
   output nwcc_pkg::item_type item
);

   logic busy_ff, busy_in;
   logic accept;

   assign accept = start & ~busy_ff;
   assign busy   = busy_ff;
   assign push   = accept;

   // Classify the command and the completion status
   always_comb begin
      item.addr     = req_addr;
      item.data     = req_write_data;
      item.len      = req_len;
      item.rdy      = req_bus_ready;
      item.acc      = req_bus_accept;
      item.st_ok    = (req_bus_status == nwcc_pkg::ST_DONE);
      item.st_nodev = (req_bus_status == nwcc_pkg::ST_NODEV);
      item.sbyte    = req_status_byte;
      unique case (req_cmd)
         nwcc_pkg::CMD_WRITE: item.op = nwcc_pkg::OP_WRITE;
         nwcc_pkg::CMD_READ:  item.op = nwcc_pkg::OP_READ;
         nwcc_pkg::CMD_POLL:  item.op = nwcc_pkg::OP_POLL;
         nwcc_pkg::CMD_DONE:  item.op = nwcc_pkg::OP_DONE;
         nwcc_pkg::CMD_TICK:  item.op = nwcc_pkg::OP_TICK;
         default:             item.op = nwcc_pkg::OP_NONE;
      endcase
   end

   // Busy from accept until the result beat goes out
   always_comb begin
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (done) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

endmodule

[hdl/nwcc_queue.sv]
// Short FIFO between the front end and the back end.
module nwcc_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  nwcc_pkg::item_type item_in,
   input  logic               pop,
   output logic               valid,
   output nwcc_pkg::item_type item_out
);

   localparam int PTR_W = (nwcc_pkg::QUEUE_DEPTH > 1) ? $clog2(nwcc_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(nwcc_pkg::QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(nwcc_pkg::QUEUE_DEPTH - 1);

   nwcc_pkg::item_type slot_ff [nwcc_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign valid    = (count_ff != '0);
   assign item_out = slot_ff[rd_ptr_ff];
   assign do_push  = push & (count_ff != CNT_W'(nwcc_pkg::QUEUE_DEPTH));
   assign do_pop   = pop & valid;

   // Pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push & ~do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop & ~do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Slot storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= item_in;
      end
   end

endmodule

[hdl/nwcc_back.sv]
// Back end: write stack with address scan, mode machine and result register.
module nwcc_back #(
   parameter int STACK_DEPTH = nwcc_pkg::STACK_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  nwcc_pkg::cfg_type  cfg,
   input  logic               q_valid,
   input  nwcc_pkg::item_type q_item,
   output logic               q_pop,
   output logic               rsp_valid,
   output nwcc_pkg::rsp_type  rsp
);

   localparam int IDX_W   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int FILL_W  = $clog2(STACK_DEPTH + 1);
   localparam int ENTRY_W = 24;
   localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(STACK_DEPTH);

   // Sequencer states
   localparam logic [1:0] B_IDLE = 2'd0;
   localparam logic [1:0] B_RD   = 2'd1;
   localparam logic [1:0] B_CMP  = 2'd2;
   localparam logic [1:0] B_EXEC = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [FILL_W-1:0]   scan_ff, scan_in;
   logic                hit_ff, hit_in;
   nwcc_pkg::item_type  cur_ff;

   nwcc_pkg::mode_type  mode_ff, mode_in;
   nwcc_pkg::kind_type  pending_ff, pending_in;
   logic [7:0]          saved_ff, saved_in;
   logic [15:0]         elapsed_ff, elapsed_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;

   logic                rsp_valid_ff;
   nwcc_pkg::rsp_type   rsp_ff, rsp_in;

   // Stack memory, entry = {address, byte}
   logic [ENTRY_W-1:0]  mem [STACK_DEPTH];
   logic [ENTRY_W-1:0]  rdata_ff;
   logic                rd_en;
   logic [IDX_W-1:0]    rd_idx;
   logic                we;
   logic [IDX_W-1:0]    wr_idx;
   logic [ENTRY_W-1:0]  wr_entry;

   logic [FILL_W-1:0]   fill_dec;
   logic [FILL_W-1:0]   scan_inc;
   logic [15:0]         rd_addr;
   logic [7:0]          rd_byte;

   assign fill_dec  = fill_ff - 1'b1;
   assign scan_inc  = scan_ff + 1'b1;
   assign rd_addr   = rdata_ff[23:8];
   assign rd_byte   = rdata_ff[7:0];
   assign rd_en     = (state_ff == B_IDLE) | (state_ff == B_RD);
   assign rd_idx    = (state_ff == B_RD) ? scan_ff[IDX_W-1:0] : fill_dec[IDX_W-1:0];
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // Sequencer: fetch a beat, scan the stack for writes, then execute
   always_comb begin
      state_in = state_ff;
      scan_in  = scan_ff;
      hit_in   = hit_ff;
      q_pop    = 1'b0;
      unique case (state_ff)
         B_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               hit_in = 1'b0;
               scan_in = '0;
               if ((q_item.op == nwcc_pkg::OP_WRITE) && (fill_ff != '0)) begin
                  state_in = B_RD;
               end else begin
                  state_in = B_EXEC;
               end
            end
         end
         B_RD: begin
            state_in = B_CMP;
         end
         B_CMP: begin
            if (rd_addr == cur_ff.addr) begin
               hit_in   = 1'b1;
               state_in = B_EXEC;
            end else if (scan_inc < fill_ff) begin
               scan_in  = scan_inc;
               state_in = B_RD;
            end else begin
               state_in = B_EXEC;
            end
         end
         B_EXEC: begin
            state_in = B_IDLE;
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   // Execute one beat: next mode, transaction fields, stack update
   always_comb begin
      rsp_in     = '0;
      mode_in    = mode_ff;
      pending_in = pending_ff;
      saved_in   = saved_ff;
      elapsed_in = elapsed_ff;
      fill_in    = fill_ff;
      we         = 1'b0;
      wr_idx     = fill_ff[IDX_W-1:0];
      wr_entry   = {cur_ff.addr, cur_ff.data};
      unique case (cur_ff.op)
         nwcc_pkg::OP_WRITE: begin
            if (hit_ff) begin
               we     = 1'b1;
               wr_idx = scan_ff[IDX_W-1:0];
            end else if (fill_ff < FILL_MAX) begin
               we      = 1'b1;
               fill_in = fill_ff + 1'b1;
            end else begin
               rsp_in.write_dropped = 1'b1;
            end
         end
         nwcc_pkg::OP_READ: begin
            if ((mode_ff == nwcc_pkg::M_IDLE) && cur_ff.rdy && cur_ff.acc) begin
               rsp_in.issue      = 1'b1;
               rsp_in.xfer_kind  = nwcc_pkg::K_ADDR_RD;
               rsp_in.rx_count   = cur_ff.len;
               rsp_in.read_taken = 1'b1;
               rsp_in.dev_addr   = nwcc_pkg::dev_for(cfg.byte_addr_mode, cur_ff.addr);
               if (cfg.byte_addr_mode) begin
                  rsp_in.tx_byte0 = cur_ff.addr[7:0];
                  rsp_in.tx_count = 2'd1;
               end else begin
                  rsp_in.tx_byte0 = cur_ff.addr[15:8];
                  rsp_in.tx_byte1 = cur_ff.addr[7:0];
                  rsp_in.tx_count = 2'd2;
               end
            end
         end
         nwcc_pkg::OP_POLL: begin
            if (mode_ff == nwcc_pkg::M_INIT) begin
               if (cur_ff.acc) begin
                  rsp_in.issue     = 1'b1;
                  rsp_in.xfer_kind = nwcc_pkg::K_STATUS_RD;
                  rsp_in.dev_addr  = nwcc_pkg::DEV_CTRL;
                  rsp_in.rx_count  = 16'd1;
               end
            end else if (mode_ff == nwcc_pkg::M_SETASE) begin
               if (cur_ff.acc) begin
                  rsp_in.issue     = 1'b1;
                  rsp_in.xfer_kind = nwcc_pkg::K_CTRL_WR;
                  rsp_in.dev_addr  = nwcc_pkg::DEV_CTRL;
                  rsp_in.tx_byte1  = saved_ff | nwcc_pkg::ASE_BIT;
                  rsp_in.tx_count  = 2'd2;
               end
            end else if (mode_ff == nwcc_pkg::M_IDLE) begin
               // Pop the newest entry; it was read while fetching the beat
               if ((fill_ff != '0) && cur_ff.rdy && cur_ff.acc) begin
                  rsp_in.issue     = 1'b1;
                  rsp_in.xfer_kind = nwcc_pkg::K_DATA_WR;
                  rsp_in.dev_addr  = nwcc_pkg::dev_for(cfg.byte_addr_mode, rd_addr);
                  fill_in          = fill_dec;
                  if (cfg.byte_addr_mode) begin
                     rsp_in.tx_byte0 = rd_addr[7:0];
                     rsp_in.tx_byte1 = rd_byte;
                     rsp_in.tx_count = 2'd2;
                  end else begin
                     rsp_in.tx_byte0 = rd_addr[15:8];
                     rsp_in.tx_byte1 = rd_addr[7:0];
                     rsp_in.tx_byte2 = rd_byte;
                     rsp_in.tx_count = 2'd3;
                  end
               end
            end else if (mode_ff == nwcc_pkg::M_BUSY) begin
               if (elapsed_ff >= cfg.timeout_ticks) begin
                  mode_in = nwcc_pkg::M_ERROR;
               end
            end
         end
         nwcc_pkg::OP_DONE: begin
            if (mode_ff == nwcc_pkg::M_BUSY) begin
               if (pending_ff == nwcc_pkg::K_STATUS_RD) begin
                  saved_in = cur_ff.sbyte;
                  if (cur_ff.st_ok) begin
                     mode_in = ((cur_ff.sbyte & nwcc_pkg::ASE_BIT) != 8'd0) ?
                               nwcc_pkg::M_IDLE : nwcc_pkg::M_SETASE;
                  end else if (cur_ff.st_nodev) begin
                     mode_in = nwcc_pkg::M_IDLE;
                  end else begin
                     mode_in = nwcc_pkg::M_ERROR;
                  end
               end else begin
                  mode_in = cur_ff.st_ok ? nwcc_pkg::M_IDLE : nwcc_pkg::M_ERROR;
               end
            end
         end
         nwcc_pkg::OP_TICK: begin
            if (elapsed_ff != nwcc_pkg::ELAPSED_MAX) begin
               elapsed_in = elapsed_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
      // A started transaction arms the busy mode
      if (rsp_in.issue) begin
         pending_in = rsp_in.xfer_kind;
         elapsed_in = '0;
         mode_in    = nwcc_pkg::M_BUSY;
      end
      rsp_in.ready_res = (mode_in == nwcc_pkg::M_IDLE);
      rsp_in.ctrl_mode = mode_in;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         scan_ff      <= '0;
         hit_ff       <= 1'b0;
         mode_ff      <= nwcc_pkg::M_INIT;
         pending_ff   <= nwcc_pkg::K_STATUS_RD;
         saved_ff     <= '0;
         elapsed_ff   <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= (state_ff == B_EXEC);
         if (state_ff == B_EXEC) begin
            mode_ff    <= mode_in;
            pending_ff <= pending_in;
            saved_ff   <= saved_in;
            elapsed_ff <= elapsed_in;
            fill_ff    <= fill_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (q_pop) begin
         cur_ff <= q_item;
      end
      if (state_ff == B_EXEC) begin
         rsp_ff <= rsp_in;
      end
   end

   // Stack memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we && (state_ff == B_EXEC)) begin
         mem[wr_idx] <= wr_entry;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_idx];
      end
   end

   // Checks
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_MAX)
      else $error("stack fill beyond depth");

   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == nwcc_pkg::M_ERROR) |=> (mode_ff == nwcc_pkg::M_ERROR))
      else $error("left error mode without reset");

   a_strobe_from_exec: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_EXEC) |=> rsp_valid_ff)
      else $error("executed beat produced no result");

   a_no_stray_strobe: assert property (@(posedge clock) disable iff (reset)
      (state_ff != B_EXEC) |=> !rsp_valid_ff)
      else $error("result strobe without execution");

   a_issue_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.issue) |-> (mode_ff == nwcc_pkg::M_BUSY))
      else $error("transaction issued but mode not busy");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_CMP) |-> (scan_ff < fill_ff))
      else $error("scan index past fill");

endmodule

[hdl/nvram_write_coalescing_controller_unit.sv]
// NVRAM write-coalescing controller: top level with configuration registers.
// A request passes through the queue, the fetch state and the execute state before its rsp_valid beat;
// a write request with stacked entries adds a read state and a compare state per entry scanned.
// A new request is accepted only once the previous one is through; busy stays high
// through the result beat. Results cannot be stalled. Synchronous reset returns mode to
// init, empties the stack and loads the configuration defaults; no clearing pass is needed.
module nvram_write_coalescing_controller_unit #(
   parameter int STACK_DEPTH = nwcc_pkg::STACK_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_cmd,
   input  logic [15:0] req_addr,
   input  logic [7:0]  req_write_data,
   input  logic [15:0] req_len,
   input  logic        req_bus_ready,
   input  logic        req_bus_accept,
   input  logic [1:0]  req_bus_status,
   input  logic [7:0]  req_status_byte,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata,
   output logic        rsp_valid,
   output logic        rsp_issue,
   output logic [1:0]  rsp_xfer_kind,
   output logic [7:0]  rsp_dev_addr,
   output logic [7:0]  rsp_tx_byte0,
   output logic [7:0]  rsp_tx_byte1,
   output logic [7:0]  rsp_tx_byte2,
   output logic [1:0]  rsp_tx_count,
   output logic [15:0] rsp_rx_count,
   output logic        rsp_ready_res,
   output logic        rsp_read_taken,
   output logic        rsp_write_dropped,
   output logic [2:0]  rsp_ctrl_mode
);

   nwcc_pkg::cfg_type  cfg_ff;
   nwcc_pkg::item_type front_item;
   nwcc_pkg::item_type q_item;
   nwcc_pkg::rsp_type  rsp;
   logic               push;
   logic               q_valid;
   logic               q_pop;
   logic               done;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.byte_addr_mode <= 1'b0;
         cfg_ff.timeout_ticks  <= nwcc_pkg::TIMEOUT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            nwcc_pkg::REG_BYTE_ADDR_MODE: cfg_ff.byte_addr_mode <= csr_wdata[0];
            nwcc_pkg::REG_TIMEOUT:        cfg_ff.timeout_ticks  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   nwcc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_cmd         (req_cmd),
      .req_addr        (req_addr),
      .req_write_data  (req_write_data),
      .req_len         (req_len),
      .req_bus_ready   (req_bus_ready),
      .req_bus_accept  (req_bus_accept),
      .req_bus_status  (req_bus_status),
      .req_status_byte (req_status_byte),
      .done            (done),
      .push            (push),
      .item            (front_item)
   );

   nwcc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .item_in  (front_item),
      .pop      (q_pop),
      .valid    (q_valid),
      .item_out (q_item)
   );

   nwcc_back #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .rsp_valid (done),
      .rsp       (rsp)
   );

   // Result ports
   assign rsp_valid         = done;
   assign rsp_issue         = rsp.issue;
   assign rsp_xfer_kind     = rsp.xfer_kind;
   assign rsp_dev_addr      = rsp.dev_addr;
   assign rsp_tx_byte0      = rsp.tx_byte0;
   assign rsp_tx_byte1      = rsp.tx_byte1;
   assign rsp_tx_byte2      = rsp.tx_byte2;
   assign rsp_tx_count      = rsp.tx_count;
   assign rsp_rx_count      = rsp.rx_count;
   assign rsp_ready_res     = rsp.ready_res;
   assign rsp_read_taken    = rsp.read_taken;
   assign rsp_write_dropped = rsp.write_dropped;
   assign rsp_ctrl_mode     = rsp.ctrl_mode;

endmodule
